[rtl/bpft_pkg.sv]
// bpft_pkg: shared constants, types and tables of the body posture foot transform
// no dependencies; used by every other file of the block
package bpft_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int LEG_COUNT    = 4;
   localparam int LEG_WIDTH    = 2;
   localparam int QUEUE_DEPTH  = 8;

   localparam int ANGLE_WIDTH  = 16;
   localparam int REG_WIDTH    = 15;
   localparam int CSR_IDX_WIDTH = 4;

   // sine/cosine and matrix elements are Q1.14 held in 18 bits
   localparam int SC_WIDTH     = 18;
   localparam int MAT_WIDTH    = 18;
   // cordic vector and angle accumulator
   localparam int ACC_WIDTH    = 34;

   localparam logic signed [ACC_WIDTH-1:0] CORDIC_X0 = 34'sd652032874;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BODY_LENGTH     = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BODY_WIDTH      = 4'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HIP_OFFSET      = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_STANDING_HEIGHT = 4'd3;

   localparam logic [REG_WIDTH-1:0] BODY_LENGTH_RST     = 15'd3200;
   localparam logic [REG_WIDTH-1:0] BODY_WIDTH_RST      = 15'd1600;
   localparam logic [REG_WIDTH-1:0] HIP_OFFSET_RST      = 15'd960;
   localparam logic [REG_WIDTH-1:0] STANDING_HEIGHT_RST = 15'd2560;

   // arctangent of 2^-i in units of pi/2^31
   localparam int ATAN_TAB [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
      652, 326, 163, 81
   };

   typedef struct packed {
      logic signed [MAT_WIDTH-1:0] ix;
      logic signed [MAT_WIDTH-1:0] iy;
      logic signed [MAT_WIDTH-1:0] iz;
      logic signed [MAT_WIDTH-1:0] jx;
      logic signed [MAT_WIDTH-1:0] jy;
      logic signed [MAT_WIDTH-1:0] jz;
      logic signed [MAT_WIDTH-1:0] kx;
      logic signed [MAT_WIDTH-1:0] ky;
      logic signed [MAT_WIDTH-1:0] kz;
   } mat_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] body_length;
      logic [REG_WIDTH-1:0] body_width;
      logic [REG_WIDTH-1:0] hip_offset;
      logic [REG_WIDTH-1:0] standing_height;
   } geom_type;

endpackage

[rtl/bpft_req_if.sv]
// bpft_req_if: posture command channel, valid/ready with payload
// depends on bpft_pkg
interface bpft_req_if #(parameter int COORD_WIDTH = bpft_pkg::COORD_WIDTH);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] shift_x;
   logic signed [COORD_WIDTH-1:0] shift_y;
   logic signed [COORD_WIDTH-1:0] shift_z;
   logic signed [bpft_pkg::ANGLE_WIDTH-1:0] roll_angle;
   logic signed [bpft_pkg::ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [bpft_pkg::ANGLE_WIDTH-1:0] yaw_angle;
   logic signed [COORD_WIDTH-1:0] pivot_x;
   logic signed [COORD_WIDTH-1:0] pivot_y;
   logic signed [COORD_WIDTH-1:0] pivot_z;

   modport source (output valid, shift_x, shift_y, shift_z, roll_angle, pitch_angle,
                   yaw_angle, pivot_x, pivot_y, pivot_z, input ready);
   modport sink (input valid, shift_x, shift_y, shift_z, roll_angle, pitch_angle,
                 yaw_angle, pivot_x, pivot_y, pivot_z, output ready);
endinterface

[rtl/bpft_rsp_if.sv]
// bpft_rsp_if: foot result channel, valid/ready with payload
// depends on bpft_pkg
interface bpft_rsp_if #(parameter int COORD_WIDTH = bpft_pkg::COORD_WIDTH);
   logic valid;
   logic ready;
   logic [bpft_pkg::LEG_WIDTH-1:0] leg_index;
   logic signed [COORD_WIDTH-1:0] foot_x;
   logic signed [COORD_WIDTH-1:0] foot_y;
   logic signed [COORD_WIDTH-1:0] foot_z;
   logic last_leg;

   modport source (output valid, leg_index, foot_x, foot_y, foot_z, last_leg, input ready);
   modport sink (input valid, leg_index, foot_x, foot_y, foot_z, last_leg, output ready);
endinterface

[rtl/bpft_csr_if.sv]
// bpft_csr_if: register write channel, valid/ready with index and data
// depends on bpft_pkg
interface bpft_csr_if;
   logic valid;
   logic ready;
   logic [bpft_pkg::CSR_IDX_WIDTH-1:0] index;
   logic [bpft_pkg::REG_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/bpft_cordic.sv]
// bpft_cordic: pipelined rotation-mode cordic, one stage per iteration
// depends on bpft_pkg
module bpft_cordic #(
   parameter int CORDIC_STEPS = bpft_pkg::CORDIC_STEPS
) (
   input  logic clock,
   input  logic signed [bpft_pkg::ANGLE_WIDTH-1:0] angle,
   output logic signed [bpft_pkg::SC_WIDTH-1:0] sin_val,
   output logic signed [bpft_pkg::SC_WIDTH-1:0] cos_val
);
   localparam int AW = bpft_pkg::ACC_WIDTH;
   localparam int SW = bpft_pkg::SC_WIDTH;

   logic signed [AW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [AW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [AW-1:0] z_ff [0:CORDIC_STEPS];
   logic                 flip_ff [0:CORDIC_STEPS];

   logic signed [bpft_pkg::ANGLE_WIDTH:0] ang_ext;
   logic signed [bpft_pkg::ANGLE_WIDTH:0] ang_red;
   logic                                  flip_in;
   logic signed [AW-1:0]                  sin_full;
   logic signed [AW-1:0]                  cos_full;
   logic signed [SW-1:0]                  sin_in;
   logic signed [SW-1:0]                  cos_in;
   logic signed [SW-1:0]                  sin_ff;
   logic signed [SW-1:0]                  cos_ff;

   // fold into the half turn around zero
   always_comb begin
      ang_ext = (bpft_pkg::ANGLE_WIDTH+1)'(angle);
      ang_red = ang_ext;
      flip_in = 1'b0;
      if (ang_ext > 17'sd16384) begin
         ang_red = ang_ext - 17'sd32768;
         flip_in = 1'b1;
      end else if (ang_ext < -17'sd16384) begin
         ang_red = ang_ext + 17'sd32768;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= bpft_pkg::CORDIC_X0;
      y_ff[0]    <= '0;
      z_ff[0]    <= AW'(ang_red) <<< 16;
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [AW-1:0] ATAN = AW'(bpft_pkg::ATAN_TAB[i]);
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ATAN;
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ATAN;
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   // round to q1.14
   always_comb begin
      sin_full = (y_ff[CORDIC_STEPS] + 34'sd32768) >>> 16;
      cos_full = (x_ff[CORDIC_STEPS] + 34'sd32768) >>> 16;
      sin_in   = flip_ff[CORDIC_STEPS] ? -sin_full[SW-1:0] : sin_full[SW-1:0];
      cos_in   = flip_ff[CORDIC_STEPS] ? -cos_full[SW-1:0] : cos_full[SW-1:0];
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;
endmodule

[rtl/bpft_front.sv]
// bpft_front: accepts commands, runs sine/cosine and the rotation matrix
// depends on bpft_pkg, bpft_req_if, bpft_cordic
module bpft_front #(
   parameter int COORD_WIDTH  = bpft_pkg::COORD_WIDTH,
   parameter int CORDIC_STEPS = bpft_pkg::CORDIC_STEPS,
   parameter int QUEUE_DEPTH  = bpft_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   bpft_req_if.sink req_chan,
   input  logic pop,
   output logic push_valid,
   output bpft_pkg::mat_type push_mat,
   output logic signed [COORD_WIDTH-1:0] push_px,
   output logic signed [COORD_WIDTH-1:0] push_py,
   output logic signed [COORD_WIDTH-1:0] push_pz,
   output logic signed [COORD_WIDTH:0] push_sx,
   output logic signed [COORD_WIDTH:0] push_sy,
   output logic signed [COORD_WIDTH:0] push_sz
);
   localparam int W   = COORD_WIDTH;
   localparam int CL  = CORDIC_STEPS + 2;
   localparam int L   = CL + 2;
   localparam int PL  = 3 * W + 3 * (W + 1);
   localparam int RW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SCW = bpft_pkg::SC_WIDTH;
   localparam int MW  = bpft_pkg::MAT_WIDTH;
   localparam int QW  = 2 * SCW;
   localparam int TW  = 3 * SCW;

   logic [RW-1:0] reserved_ff, reserved_in;
   logic          accept;
   logic          vld_ff [0:L-1];
   logic [PL-1:0] pay_ff [0:L-1];
   logic [PL-1:0] pay_in;

   logic signed [SCW-1:0] sr, cr, sp, cp, sy, cy;
   logic signed [SCW-1:0] sr_ff, cr_ff, sp_ff;
   logic signed [QW-1:0]  cycp_ff, sycp_ff, cysp_ff, sysp_ff, cpsr_ff, cpcr_ff;
   logic signed [QW-1:0]  sycr_ff, sysr_ff, cycr_ff, cysr_ff;
   logic signed [TW-1:0]  t_iy, t_iz, t_jy, t_jz;
   logic signed [QW-1:0]  t_ix, t_jx, t_ky, t_kz;
   bpft_pkg::mat_type     mat_ff, mat_in;
   logic signed [W:0]     sx_in, sy_in, sz_in;

   // credits cover both the pipeline and the queue
   assign req_chan.ready = reserved_ff < RW'(QUEUE_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;
   assign reserved_in = reserved_ff + RW'(accept) - RW'(pop);

   always_comb begin
      sx_in  = (W+1)'(req_chan.shift_x) + (W+1)'(req_chan.pivot_x);
      sy_in  = (W+1)'(req_chan.shift_y) + (W+1)'(req_chan.pivot_y);
      sz_in  = (W+1)'(req_chan.shift_z) + (W+1)'(req_chan.pivot_z);
      pay_in = {req_chan.pivot_x, req_chan.pivot_y, req_chan.pivot_z, sx_in, sy_in, sz_in};
   end

   bpft_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock(clock), .angle(req_chan.roll_angle), .sin_val(sr), .cos_val(cr));
   bpft_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock(clock), .angle(req_chan.pitch_angle), .sin_val(sp), .cos_val(cp));
   bpft_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
      .clock(clock), .angle(req_chan.yaw_angle), .sin_val(sy), .cos_val(cy));

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         for (int i = 0; i < L; i++) vld_ff[i] <= 1'b0;
      end else begin
         reserved_ff <= reserved_in;
         vld_ff[0]   <= accept;
         for (int i = 1; i < L; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      pay_ff[0] <= pay_in;
      for (int i = 1; i < L; i++) pay_ff[i] <= pay_ff[i-1];
   end

   // first matrix stage: pairwise products
   always_ff @(posedge clock) begin
      cycp_ff <= cy * cp;
      sycp_ff <= sy * cp;
      cysp_ff <= cy * sp;
      sysp_ff <= sy * sp;
      cpsr_ff <= cp * sr;
      cpcr_ff <= cp * cr;
      sycr_ff <= sy * cr;
      sysr_ff <= sy * sr;
      cycr_ff <= cr * cy;
      cysr_ff <= cy * sr;
      sr_ff   <= sr;
      cr_ff   <= cr;
      sp_ff   <= sp;
   end

   // second matrix stage: third factor and rounding
   always_comb begin
      t_iy = (cysp_ff * sr_ff - (TW'(sycr_ff) <<< 14) + 54'sd134217728) >>> 28;
      t_iz = (cysp_ff * cr_ff + (TW'(sysr_ff) <<< 14) + 54'sd134217728) >>> 28;
      t_jy = (sysp_ff * sr_ff + (TW'(cycr_ff) <<< 14) + 54'sd134217728) >>> 28;
      t_jz = (sysp_ff * cr_ff - (TW'(cysr_ff) <<< 14) + 54'sd134217728) >>> 28;
      t_ix = (cycp_ff + 36'sd8192) >>> 14;
      t_jx = (sycp_ff + 36'sd8192) >>> 14;
      t_ky = (cpsr_ff + 36'sd8192) >>> 14;
      t_kz = (cpcr_ff + 36'sd8192) >>> 14;
      mat_in.ix = t_ix[MW-1:0];
      mat_in.iy = t_iy[MW-1:0];
      mat_in.iz = t_iz[MW-1:0];
      mat_in.jx = t_jx[MW-1:0];
      mat_in.jy = t_jy[MW-1:0];
      mat_in.jz = t_jz[MW-1:0];
      mat_in.kx = -MW'(sp_ff);
      mat_in.ky = t_ky[MW-1:0];
      mat_in.kz = t_kz[MW-1:0];
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   assign push_valid = vld_ff[L-1];
   assign push_mat   = mat_ff;
   assign {push_px, push_py, push_pz, push_sx, push_sy, push_sz} = pay_ff[L-1];
endmodule

[rtl/bpft_queue.sv]
// bpft_queue: short register queue between front and back
// depends on bpft_pkg
module bpft_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bpft_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   input  logic pop,
   output logic head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];
endmodule

[rtl/bpft_back.sv]
// bpft_back: walks the four legs of a queued command, one leg per cycle unless the output stalls
// depends on bpft_pkg, bpft_rsp_if
module bpft_back #(
   parameter int COORD_WIDTH = bpft_pkg::COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  bpft_pkg::geom_type geom,
   input  logic head_valid,
   input  bpft_pkg::mat_type head_mat,
   input  logic signed [COORD_WIDTH-1:0] head_px,
   input  logic signed [COORD_WIDTH-1:0] head_py,
   input  logic signed [COORD_WIDTH-1:0] head_pz,
   input  logic signed [COORD_WIDTH:0] head_sx,
   input  logic signed [COORD_WIDTH:0] head_sy,
   input  logic signed [COORD_WIDTH:0] head_sz,
   output logic pop,
   bpft_rsp_if.source rsp_chan
);
   localparam int W  = COORD_WIDTH;
   localparam int LW = bpft_pkg::LEG_WIDTH;
   localparam int MW = bpft_pkg::MAT_WIDTH;
   localparam int VW = ((W + 2 > 18) ? W + 2 : 18) + 1;
   localparam int PW = MW + VW;
   localparam int OW = PW + 3;
   localparam logic signed [OW-1:0] SAT_HI = {{(OW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [OW-1:0] SAT_LO = ~SAT_HI;

   logic          en, issue;
   logic [LW-1:0] leg_ff, leg_in;

   // stage one
   logic              b1_vld_ff;
   logic [LW-1:0]     b1_leg_ff;
   bpft_pkg::mat_type b1_mat_ff;
   logic signed [VW-1:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic signed [OW-1:0] c1x_ff, c1y_ff, c1z_ff, c1x_in, c1y_in, c1z_in;
   logic signed [VW-1:0] comx, comy, offy, len_s, wid_s, hip_s, hgt_s;

   // stage two
   logic              b2_vld_ff;
   logic [LW-1:0]     b2_leg_ff;
   logic signed [PW-1:0] pxx_ff, pxy_ff, pxz_ff, pyx_ff, pyy_ff, pyz_ff;
   logic signed [PW-1:0] pzx_ff, pzy_ff, pzz_ff;
   logic signed [OW-1:0] c2x_ff, c2y_ff, c2z_ff;

   // stage three
   logic signed [OW-1:0] ox, oy, oz, rx, ry, rz;
   logic              rsp_vld_ff;
   logic [LW-1:0]     rsp_leg_ff;
   logic signed [W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_x_in, rsp_y_in, rsp_z_in;
   logic              rsp_last_ff;

   function automatic logic signed [W-1:0] round_sat(input logic signed [OW-1:0] v);
      logic signed [OW-1:0] r;
      r = (v + (OW'(1) <<< 14)) >>> 15;
      if (r > SAT_HI) return SAT_HI[W-1:0];
      else if (r < SAT_LO) return SAT_LO[W-1:0];
      else return r[W-1:0];
   endfunction

   assign en    = !rsp_vld_ff || rsp_chan.ready;
   assign issue = en && head_valid;
   assign pop   = issue && (leg_ff == LW'(bpft_pkg::LEG_COUNT - 1));
   assign leg_in = issue ? leg_ff + 1'b1 : leg_ff;

   always_comb begin
      len_s = VW'({1'b0, geom.body_length});
      wid_s = VW'({1'b0, geom.body_width});
      hip_s = VW'({1'b0, geom.hip_offset});
      hgt_s = VW'({1'b0, geom.standing_height});
      // leg bit 1 set means back, bit 0 set means right
      comx  = leg_ff[1] ? -len_s : len_s;
      comy  = leg_ff[0] ? -wid_s : wid_s;
      offy  = leg_ff[0] ? -(hip_s <<< 1) : (hip_s <<< 1);
      vx_in = comx - (VW'(head_sx) <<< 1);
      vy_in = comy + offy - (VW'(head_sy) <<< 1);
      vz_in = (hgt_s <<< 1) - (VW'(head_sz) <<< 1);
      c1x_in = (OW'(head_px) <<< 15) - (OW'(comx) <<< 14);
      c1y_in = (OW'(head_py) <<< 15) - (OW'(comy) <<< 14);
      c1z_in = OW'(head_pz) <<< 15;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_ff     <= '0;
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         leg_ff <= leg_in;
         if (en) begin
            b1_vld_ff  <= head_valid;
            b2_vld_ff  <= b1_vld_ff;
            rsp_vld_ff <= b2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_leg_ff <= leg_ff;
         b1_mat_ff <= head_mat;
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
         vz_ff     <= vz_in;
         c1x_ff    <= c1x_in;
         c1y_ff    <= c1y_in;
         c1z_ff    <= c1z_in;

         b2_leg_ff <= b1_leg_ff;
         pxx_ff    <= b1_mat_ff.ix * vx_ff;
         pxy_ff    <= b1_mat_ff.jx * vy_ff;
         pxz_ff    <= b1_mat_ff.kx * vz_ff;
         pyx_ff    <= b1_mat_ff.iy * vx_ff;
         pyy_ff    <= b1_mat_ff.jy * vy_ff;
         pyz_ff    <= b1_mat_ff.ky * vz_ff;
         pzx_ff    <= b1_mat_ff.iz * vx_ff;
         pzy_ff    <= b1_mat_ff.jz * vy_ff;
         pzz_ff    <= b1_mat_ff.kz * vz_ff;
         c2x_ff    <= c1x_ff;
         c2y_ff    <= c1y_ff;
         c2z_ff    <= c1z_ff;

         rsp_leg_ff  <= b2_leg_ff;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_z_ff    <= rsp_z_in;
         rsp_last_ff <= b2_leg_ff == LW'(bpft_pkg::LEG_COUNT - 1);
      end
   end

   always_comb begin
      ox = OW'(pxx_ff) + OW'(pxy_ff) + OW'(pxz_ff) + c2x_ff;
      oy = OW'(pyx_ff) + OW'(pyy_ff) + OW'(pyz_ff) + c2y_ff;
      oz = OW'(pzx_ff) + OW'(pzy_ff) + OW'(pzz_ff) + c2z_ff;
      rx = ox;
      ry = b2_leg_ff[0] ? -oy : oy;
      rz = oz;
      rsp_x_in = round_sat(rx);
      rsp_y_in = round_sat(ry);
      rsp_z_in = round_sat(rz);
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.leg_index = rsp_leg_ff;
   assign rsp_chan.foot_x    = rsp_x_ff;
   assign rsp_chan.foot_y    = rsp_y_ff;
   assign rsp_chan.foot_z    = rsp_z_ff;
   assign rsp_chan.last_leg  = rsp_last_ff;
endmodule

[rtl/body_posture_foot_transform.sv]
// body_posture_foot_transform: top level, registers, front, queue and back
// depends on bpft_pkg, the three channel interfaces, bpft_front, bpft_queue, bpft_back
//
// usage
// - req_chan carries one posture command per transfer: translation, roll,
//   pitch and yaw, and the pivot point
// - rsp_chan answers each command with four transfers, legs front-left,
//   front-right, back-left, back-right, last_leg set on the fourth
// - csr_chan writes the geometry registers; it is always ready and is
//   meant to be written only while no command is in flight
// - the first leg leaves after the front pipeline, the queue and the back end
//   stages; the other three follow one per cycle while the receiver is ready
// - the back end computes one leg per cycle while the receiver is ready and so
//   sets the command rate; the front pipeline could take one command a cycle
// - the front takes commands while fewer than QUEUE_DEPTH are in the pipeline or
//   the queue, so it keeps accepting while results wait on a stalled receiver
// - a stalled receiver freezes the back end only; results are never dropped
// - reset clears all valid state and loads the default geometry
module body_posture_foot_transform #(
   parameter int COORD_WIDTH  = bpft_pkg::COORD_WIDTH,
   parameter int CORDIC_STEPS = bpft_pkg::CORDIC_STEPS
) (
   input logic clock,
   input logic reset,
   bpft_req_if.sink   req_chan,
   bpft_rsp_if.source rsp_chan,
   bpft_csr_if.sink   csr_chan
);
   localparam int W     = COORD_WIDTH;
   localparam int DEPTH = bpft_pkg::QUEUE_DEPTH;
   localparam int EW    = $bits(bpft_pkg::mat_type) + 3 * W + 3 * (W + 1);

   // geometry registers
   bpft_pkg::geom_type geom_ff, geom_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      geom_in = geom_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bpft_pkg::REG_BODY_LENGTH:     geom_in.body_length     = csr_chan.data;
            bpft_pkg::REG_BODY_WIDTH:      geom_in.body_width      = csr_chan.data;
            bpft_pkg::REG_HIP_OFFSET:      geom_in.hip_offset      = csr_chan.data;
            bpft_pkg::REG_STANDING_HEIGHT: geom_in.standing_height = csr_chan.data;
            default: ; // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.body_length     <= bpft_pkg::BODY_LENGTH_RST;
         geom_ff.body_width      <= bpft_pkg::BODY_WIDTH_RST;
         geom_ff.hip_offset      <= bpft_pkg::HIP_OFFSET_RST;
         geom_ff.standing_height <= bpft_pkg::STANDING_HEIGHT_RST;
      end else begin
         geom_ff <= geom_in;
      end
   end

   // front to queue
   logic                 push_valid;
   bpft_pkg::mat_type    push_mat;
   logic signed [W-1:0]  push_px, push_py, push_pz;
   logic signed [W:0]    push_sx, push_sy, push_sz;
   logic                 pop;

   bpft_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .CORDIC_STEPS(CORDIC_STEPS),
      .QUEUE_DEPTH(DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .pop(pop),
      .push_valid(push_valid),
      .push_mat(push_mat),
      .push_px(push_px),
      .push_py(push_py),
      .push_pz(push_pz),
      .push_sx(push_sx),
      .push_sy(push_sy),
      .push_sz(push_sz)
   );

   // queue of finished matrices with their offsets
   logic          head_valid;
   logic [EW-1:0] head_data;
   bpft_pkg::mat_type   head_mat;
   logic signed [W-1:0] head_px, head_py, head_pz;
   logic signed [W:0]   head_sx, head_sy, head_sz;

   bpft_queue #(
      .WIDTH(EW),
      .DEPTH(DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push_valid),
      .push_data({push_mat, push_px, push_py, push_pz, push_sx, push_sy, push_sz}),
      .pop(pop),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   assign {head_mat, head_px, head_py, head_pz, head_sx, head_sy, head_sz} = head_data;

   // per-leg transform and output register
   bpft_back #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .geom(geom_ff),
      .head_valid(head_valid),
      .head_mat(head_mat),
      .head_px(head_px),
      .head_py(head_py),
      .head_pz(head_pz),
      .head_sx(head_sx),
      .head_sy(head_sy),
      .head_sz(head_sz),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );
endmodule

[test/tb_chan_if.sv]
`timescale 1ns / 100ps
// tb_chan_if: no extra interfaces needed, the block's own channel interfaces are used
// this file holds the shared result and posture types of the tb; depends on bpft_pkg
package tb_types_pkg;
   typedef struct {
      logic [bpft_pkg::LEG_WIDTH-1:0] leg;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
      logic last;
   } foot_type;

   typedef struct {
      logic signed [15:0] sx, sy, sz, roll, pitch, yaw, px, py, pz;
   } posture_type;
endpackage

[test/tb.sv]
`timescale 1ns / 100ps
// tb: testbench of body_posture_foot_transform, predicts four foot points per posture
// command and checks every result transfer; depends on bpft_pkg, tb_types_pkg, the channel interfaces
module tb;
   // index outside the register list, the block ignores the write
   localparam logic [bpft_pkg::CSR_IDX_WIDTH-1:0] REG_UNUSED = 4'd9;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   bpft_req_if req_chan ();
   bpft_rsp_if rsp_chan ();
   bpft_csr_if csr_chan ();

   body_posture_foot_transform dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   // predictor copy of the geometry registers
   longint geo_length = 3200, geo_width = 1600, geo_hip = 960, geo_height = 2560;

   tb_types_pkg::posture_type pending_postures[$];
   tb_types_pkg::foot_type expected_feet[$];
   int errors = 0;
   int watchdog = 0;
   bit quiet_tail = 0;     // no idling near the end
   bit send_hold = 0;      // sender pauses
   int rsp_hold = 0;       // long receiver hold-off, counted in the monitor

   // ---------------- fixed-point helpers ----------------
   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // rotation-mode cordic, half-turn reduction outside +-90 degrees
   task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = 652032874; y = 0; flip = 0;
      if (ang > 16384) begin
         ang -= 32768; flip = 1;
      end else if (ang < -16384) begin
         ang += 32768; flip = 1;
      end
      z = ang * 65536;
      for (int i = 0; i < bpft_pkg::CORDIC_STEPS; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= bpft_pkg::ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += bpft_pkg::ATAN_TAB[i];
         end
      end
      s = (y + 32768) >>> 16;
      c = (x + 32768) >>> 16;
      if (flip) begin
         s = -s; c = -c;
      end
   endtask

   function automatic longint rnd14(longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic longint rnd28(longint v);
      return (v + 134217728) >>> 28;
   endfunction

   // four expected foot results for one posture command
   task automatic predict_feet(input tb_types_pkg::posture_type p);
      longint sr, cr, sp, cp, sy, cy;
      longint ix, iy, iz, jx, jy, jz, kx, ky, kz;
      longint comx, comy, fy, vx, vy, vz, ox, oy, oz;
      longint tx, ty, tz, px, py, pz;
      tb_types_pkg::foot_type r;
      tx = p.sx; ty = p.sy; tz = p.sz; px = p.px; py = p.py; pz = p.pz;
      cordic_sin_cos(longint'(p.roll), sr, cr);
      cordic_sin_cos(longint'(p.pitch), sp, cp);
      cordic_sin_cos(longint'(p.yaw), sy, cy);
      ix = rnd14(cy * cp);
      iy = rnd28(cy * sp * sr - sy * cr * 16384);
      iz = rnd28(cy * sp * cr + sy * sr * 16384);
      jx = rnd14(sy * cp);
      jy = rnd28(sy * sp * sr + cr * cy * 16384);
      jz = rnd28(sy * sp * cr - cy * sr * 16384);
      kx = -sp;
      ky = rnd14(cp * sr);
      kz = rnd14(cp * cr);
      for (int k = 0; k < 4; k++) begin
         comx = (k < 2) ? geo_length : -geo_length;
         comy = (k % 2 == 0) ? geo_width : -geo_width;
         fy = (k % 2 == 0) ? 2 * geo_hip : -2 * geo_hip;
         vx = comx - 2 * px - 2 * tx;
         vy = comy + fy - 2 * py - 2 * ty;
         vz = 2 * geo_height - 2 * pz - 2 * tz;
         ox = ix * vx + jx * vy + kx * vz - comx * 16384 + px * 32768;
         oy = iy * vx + jy * vy + ky * vz - comy * 16384 + py * 32768;
         oz = iz * vx + jz * vy + kz * vz + pz * 32768;
         if (k % 2 == 1) oy = -oy;
         r.leg = k[1:0];
         r.fx = 16'(clamp16((ox + 16384) >>> 15));
         r.fy = 16'(clamp16((oy + 16384) >>> 15));
         r.fz = 16'(clamp16((oz + 16384) >>> 15));
         r.last = (k == 3);
         expected_feet.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------- driver ----------------
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_feet(pending_postures.pop_front());
         end
         // decide the next offer; valid only changes once per step
         if (req_chan.valid && !req_chan.ready) begin
            // hold the current offer
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 0;
         end else if (pending_postures.size() > 0 && !send_hold) begin
            req_chan.valid <= 1;
            req_chan.shift_x <= pending_postures[0].sx;
            req_chan.shift_y <= pending_postures[0].sy;
            req_chan.shift_z <= pending_postures[0].sz;
            req_chan.roll_angle <= pending_postures[0].roll;
            req_chan.pitch_angle <= pending_postures[0].pitch;
            req_chan.yaw_angle <= pending_postures[0].yaw;
            req_chan.pivot_x <= pending_postures[0].px;
            req_chan.pivot_y <= pending_postures[0].py;
            req_chan.pivot_z <= pending_postures[0].pz;
            if (!quiet_tail && $urandom_range(0, 9) == 0)
               send_gap <= $urandom_range(1, 18);
         end else begin
            req_chan.valid <= 0;
         end
      end
   end

   // ---------------- monitor ----------------
   int rsp_gap = 0;
   always @(posedge clock) begin
      tb_types_pkg::foot_type w;
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_feet.size() == 0) begin
               report_mismatch("unexpected result, leg", rsp_chan.leg_index, -1);
            end else begin
               w = expected_feet.pop_front();
               if (rsp_chan.leg_index !== w.leg)
                  report_mismatch("leg_index", rsp_chan.leg_index, w.leg);
               if (rsp_chan.foot_x !== w.fx)
                  report_mismatch("foot_x", rsp_chan.foot_x, w.fx);
               if (rsp_chan.foot_y !== w.fy)
                  report_mismatch("foot_y", rsp_chan.foot_y, w.fy);
               if (rsp_chan.foot_z !== w.fz)
                  report_mismatch("foot_z", rsp_chan.foot_z, w.fz);
               if (rsp_chan.last_leg !== w.last)
                  report_mismatch("last_leg", rsp_chan.last_leg, w.last);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_chan.ready <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
            if (!quiet_tail && $urandom_range(0, 7) == 0)
               rsp_gap <= $urandom_range(1, 18);
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || csr_chan.valid)
            watchdog <= 0;
         else
            watchdog <= watchdog + 1;
         if (watchdog > 3000) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 1600)) - 800);
      endcase
   endfunction

   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'($urandom_range(16380, 16390));
         2: return -16'($urandom_range(16380, 16390));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic tb_types_pkg::posture_type random_posture();
      tb_types_pkg::posture_type p;
      p.sx = pick_coord(); p.sy = pick_coord(); p.sz = pick_coord();
      p.px = pick_coord(); p.py = pick_coord(); p.pz = pick_coord();
      p.roll = pick_angle(); p.pitch = pick_angle(); p.yaw = pick_angle();
      return p;
   endfunction

   function automatic tb_types_pkg::posture_type flat_posture(logic signed [15:0] c,
                                                              logic signed [15:0] a);
      tb_types_pkg::posture_type p;
      p.sx = c; p.sy = c; p.sz = c; p.px = c; p.py = c; p.pz = c;
      p.roll = a; p.pitch = a; p.yaw = a;
      return p;
   endfunction

   // register write; only while nothing is in flight
   task automatic write_geometry(input logic [bpft_pkg::CSR_IDX_WIDTH-1:0] idx,
                                 input logic [bpft_pkg::REG_WIDTH-1:0] val);
      @(posedge clock);
      csr_chan.valid <= 1; csr_chan.index <= idx; csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      case (idx)
         bpft_pkg::REG_BODY_LENGTH: geo_length = val;
         bpft_pkg::REG_BODY_WIDTH: geo_width = val;
         bpft_pkg::REG_HIP_OFFSET: geo_hip = val;
         bpft_pkg::REG_STANDING_HEIGHT: geo_height = val;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_postures.size() == 0 && !req_chan.valid && expected_feet.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      tb_types_pkg::posture_type p;
      csr_chan.valid = 0; csr_chan.index = '0; csr_chan.data = '0;
      req_chan.valid = 0;
      req_chan.shift_x = 0; req_chan.shift_y = 0; req_chan.shift_z = 0;
      req_chan.roll_angle = 0; req_chan.pitch_angle = 0; req_chan.yaw_angle = 0;
      req_chan.pivot_x = 0; req_chan.pivot_y = 0; req_chan.pivot_z = 0;
      rsp_chan.ready = 0;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: zero, extremes, angle edges with reset geometry
      pending_postures.push_back(flat_posture(0, 0));
      pending_postures.push_back(flat_posture(16'sh7fff, 16'sh7fff));
      pending_postures.push_back(flat_posture(16'sh8000, 16'sh8000));
      pending_postures.push_back(flat_posture(16'sh0010, 16384));
      pending_postures.push_back(flat_posture(-16'sh0010, -16384));
      pending_postures.push_back(flat_posture(100, 16385));
      pending_postures.push_back(flat_posture(-100, -16385));
      pending_postures.push_back(flat_posture(16'sh5555, 16'sh5555));
      pending_postures.push_back(flat_posture(16'shaaaa, 16'shaaaa));
      p = flat_posture(0, 0); p.roll = 16'sh8000; pending_postures.push_back(p);
      p = flat_posture(0, 0); p.pitch = 8192; pending_postures.push_back(p);
      p = flat_posture(0, 0); p.yaw = -8192; pending_postures.push_back(p);
      drain();

      // extreme geometry, including an index the block ignores
      write_geometry(bpft_pkg::REG_BODY_LENGTH, 15'h7fff);
      write_geometry(bpft_pkg::REG_BODY_WIDTH, 15'h7fff);
      write_geometry(bpft_pkg::REG_HIP_OFFSET, 15'h7fff);
      write_geometry(bpft_pkg::REG_STANDING_HEIGHT, 15'h7fff);
      write_geometry(REG_UNUSED, 15'h1234);
      for (int i = 0; i < 6; i++) pending_postures.push_back(random_posture());
      pending_postures.push_back(flat_posture(16'sh7fff, 0));
      drain();
      write_geometry(bpft_pkg::REG_BODY_LENGTH, '0);
      write_geometry(bpft_pkg::REG_BODY_WIDTH, '0);
      write_geometry(bpft_pkg::REG_HIP_OFFSET, '0);
      write_geometry(bpft_pkg::REG_STANDING_HEIGHT, '0);
      pending_postures.push_back(flat_posture(16'sh8000, 0));
      pending_postures.push_back(flat_posture(0, 0));

      // random phases with fresh geometry between them
      for (int ph = 0; ph < 5; ph++) begin
         for (int i = 0; i < 60; i++) pending_postures.push_back(random_posture());
         if (ph == 1) begin
            // long receiver hold-off while commands keep coming
            rsp_hold <= 400;
         end
         if (ph == 2) begin
            // sender pauses until every result has come
            wait (pending_postures.size() < 30);
            send_hold = 1;
            wait (expected_feet.size() == 0 && !req_chan.valid);
            send_hold = 0;
         end
         drain();
         write_geometry(bpft_pkg::REG_BODY_LENGTH, 15'($urandom));
         write_geometry(bpft_pkg::REG_BODY_WIDTH, 15'($urandom));
         write_geometry(bpft_pkg::REG_HIP_OFFSET, 15'($urandom));
         write_geometry(bpft_pkg::REG_STANDING_HEIGHT, 15'($urandom));
      end

      // tail without idling
      quiet_tail = 1;
      for (int i = 0; i < 30; i++) pending_postures.push_back(random_posture());
      drain();

      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
